>>> sv/tmtw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared codes, field widths and controller/datapath interface types for the
// text-mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

  // field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int RCOL_W     = 7;
  localparam int RROW_W     = 5;
  localparam int OCOL_W     = 7;
  localparam int OROW_W     = 5;
  localparam int COLOR_W    = 4;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic exec;
    logic copy_step;
    logic fill_step;
    logic fill_init;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_clear;
    logic op_scroll;
    logic copy_end;
    logic fill_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> sv/tmtw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_ctrl
// Sequencer for the terminal writer: reset fill, command execution, scroll
// copy, fill sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tmtw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tmtw_pkg::dp_status_t  sts,
  output tmtw_pkg::ctl_cmd_t         ctl
);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_EXEC = 6'b000100,
    ST_COPY = 6'b001000,
    ST_FILL = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_INIT: begin
        ctl.fill_step = 1'b1;
        ctl.fill_init = 1'b1;
        if (sts.fill_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        priority if (sts.op_clear) begin
          state_next = ST_FILL;
        end else if (sts.op_scroll) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        ctl.copy_step = 1'b1;
        if (sts.copy_end) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        ctl.fill_step = 1'b1;
        if (sts.fill_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // result goes out and the next beat may come in on the same edge
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            ctl.take_in = 1'b1;
            state_next  = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tmtw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_datapath
// Cell memory, cursor, attribute registers, sweep counter and output stage
// of the terminal writer.
// ----------------------------------------------------------------------------
module tmtw_datapath #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tmtw_pkg::ctl_cmd_t                 ctl,
  output tmtw_pkg::dp_status_t                    sts,
  input  wire logic                               cfg_write,
  input  wire logic [tmtw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tmtw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [tmtw_pkg::CMD_W-1:0]         cmd,
  input  wire logic [tmtw_pkg::CHAR_W-1:0]        char_code,
  input  wire logic [tmtw_pkg::RCOL_W-1:0]        read_col,
  input  wire logic [tmtw_pkg::RROW_W-1:0]        read_row,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tmtw_pkg::OCOL_W-1:0]             cursor_col,
  output logic [tmtw_pkg::OROW_W-1:0]             cursor_row,
  output logic                                    scrolled,
  output logic [tmtw_pkg::CHAR_W-1:0]             cell_char,
  output logic [tmtw_pkg::ATTR_W-1:0]             cell_attr
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int TW       = $clog2(COLUMNS + TAB_STOP);
  localparam int PW       = $clog2(TAB_STOP);
  localparam int COPY_LEN = (ROWS - 1) * COLUMNS;

  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_A = ADDR_W'(COPY_LEN);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CELLS - 1);

  // configuration
  logic [tmtw_pkg::COLOR_W-1:0] fg;
  logic [tmtw_pkg::COLOR_W-1:0] bg;
  logic [tmtw_pkg::ATTR_W-1:0]  attr;

  // latched command
  logic [tmtw_pkg::CMD_W-1:0]  cmd_q;
  logic [tmtw_pkg::CHAR_W-1:0] char_q;
  logic [tmtw_pkg::RCOL_W-1:0] rcol_q;
  logic [tmtw_pkg::RROW_W-1:0] rrow_q;

  // cursor; phase is the column modulo the tab stop
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] phase;
  logic          scrolled_q;
  logic          rd_ok;

  logic [ADDR_W-1:0] cnt;

  logic [tmtw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tmtw_pkg::CELL_W-1:0] rd_q;

  // put-character evaluation
  logic [TW-1:0]               col_t;
  logic [RW:0]                 row_t;
  logic [PW-1:0]               phase_n;
  logic                        put_we;
  logic [CW-1:0]               put_col;
  logic [tmtw_pkg::CHAR_W-1:0] put_char;
  logic                        scroll_c;
  logic [CW-1:0]               col_fin;
  logic [RW-1:0]               row_fin;
  logic                        in_range;
  logic [ADDR_W-1:0]           cur_addr;
  logic [ADDR_W-1:0]           rd_addr;

  // memory port
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_wa;
  logic [tmtw_pkg::CELL_W-1:0] mem_wd;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_ra;

  assign attr = {bg, fg};

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= 4'd15;
      bg <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tmtw_pkg::REG_FOREGROUND: fg <= cfg_data;
        tmtw_pkg::REG_BACKGROUND: bg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_q  <= cmd;
      char_q <= char_code;
      rcol_q <= read_col;
      rrow_q <= read_row;
    end
  end

  always_comb begin
    col_t    = TW'(col);
    row_t    = (RW + 1)'(row);
    phase_n  = phase;
    put_we   = 1'b0;
    put_col  = col;
    put_char = char_q;
    unique case (char_q)
      tmtw_pkg::CH_NEWLINE: begin
        col_t   = '0;
        row_t   = row_t + 1'b1;
        phase_n = '0;
      end
      tmtw_pkg::CH_RETURN: begin
        col_t   = '0;
        phase_n = '0;
      end
      tmtw_pkg::CH_TAB: begin
        col_t   = TW'(col) + TW'(TAB_STOP) - TW'(phase);
        phase_n = '0;
      end
      tmtw_pkg::CH_BACKSPACE: begin
        if (col != '0) begin
          col_t    = TW'(col) - 1'b1;
          put_col  = col - 1'b1;
          put_char = tmtw_pkg::CH_BLANK;
          put_we   = 1'b1;
          phase_n  = (phase == '0) ? PW'(TAB_STOP - 1) : phase - 1'b1;
        end
      end
      default: begin
        put_we  = 1'b1;
        col_t   = TW'(col) + 1'b1;
        phase_n = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + 1'b1;
      end
    endcase
    // wrap at the right edge
    if (col_t >= TW'(COLUMNS)) begin
      col_t   = '0;
      row_t   = row_t + 1'b1;
      phase_n = '0;
    end
    scroll_c = (row_t >= (RW + 1)'(ROWS));
    col_fin  = CW'(col_t);
    row_fin  = scroll_c ? RW'(ROWS - 1) : RW'(row_t);
  end

  assign in_range = (32'(rcol_q) < 32'(COLUMNS)) && (32'(rrow_q) < 32'(ROWS));
  assign cur_addr = ADDR_W'(row) * COLS_A + ADDR_W'(put_col);
  assign rd_addr  = ADDR_W'(rrow_q) * COLS_A + ADDR_W'(rcol_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      phase <= '0;
    end else if (ctl.exec) begin
      unique case (cmd_q)
        tmtw_pkg::CMD_PUT: begin
          col   <= col_fin;
          row   <= row_fin;
          phase <= phase_n;
        end
        tmtw_pkg::CMD_CLEAR: begin
          col   <= '0;
          row   <= '0;
          phase <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      scrolled_q <= (cmd_q == tmtw_pkg::CMD_PUT) && scroll_c;
      rd_ok      <= (cmd_q == tmtw_pkg::CMD_READ) && in_range;
    end
  end

  // sweep counter: scroll copy runs from row one down, fills run to the end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      priority if (ctl.exec) begin
        cnt <= '0;
      end else if (ctl.copy_step) begin
        if (cnt != COPY_A) begin
          cnt <= cnt + 1'b1;
        end
      end else if (ctl.fill_step) begin
        if (cnt != LAST_A) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_addr;
    mem_wd = {attr, put_char};
    mem_re = 1'b0;
    mem_ra = rd_addr;
    priority if (ctl.exec) begin
      mem_we = (cmd_q == tmtw_pkg::CMD_PUT) && put_we;
      mem_re = (cmd_q == tmtw_pkg::CMD_READ);
    end else if (ctl.copy_step) begin
      // read one row below, write the cell fetched last cycle
      mem_we = (cnt != '0);
      mem_wa = cnt - 1'b1;
      mem_wd = rd_q;
      mem_re = (cnt != COPY_A);
      mem_ra = cnt + COLS_A;
    end else if (ctl.fill_step) begin
      mem_we = 1'b1;
      mem_wa = cnt;
      mem_wd = {(ctl.fill_init ? tmtw_pkg::RESET_ATTR : attr), tmtw_pkg::CH_BLANK};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign sts.op_clear  = (cmd_q == tmtw_pkg::CMD_CLEAR);
  assign sts.op_scroll = (cmd_q == tmtw_pkg::CMD_PUT) && scroll_c;
  assign sts.copy_end  = (cnt == COPY_A);
  assign sts.fill_end  = (cnt == LAST_A);
  assign sts.out_free  = !out_valid || out_ready;

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      cursor_col <= tmtw_pkg::OCOL_W'(col);
      cursor_row <= tmtw_pkg::OROW_W'(row);
      scrolled   <= scrolled_q;
      cell_char  <= rd_ok ? rd_q[tmtw_pkg::CHAR_W-1:0] : '0;
      cell_attr  <= rd_ok ? rd_q[tmtw_pkg::CELL_W-1:tmtw_pkg::CHAR_W] : '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/text_mode_terminal_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Character-cell terminal: cell memory with cursor, put-character, clear and
// read-cell commands, one result beat per command.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_ready       cmd, char_code, read_col, read_row
//  out      out_valid / out_ready     cursor_col, cursor_row, scrolled,
//                                     cell_char, cell_attr
//  cfg      cfg_write                 cfg_index, cfg_data
//
// put-character without scroll, read and unused codes: an execute step, then a
// result step that overlaps with the next accept.
// clear: a fill sweep, one cell written per cycle on the memory port.
// scroll: row copy through the memory read/write pair, then blanking of the
// bottom row.
// after reset a fill pass over all COLUMNS*ROWS cells (2000 by default) runs with
// in_ready low; configuration writes are taken throughout.
// a stalled result holds in the output register; the next command is accepted
// and executed meanwhile, then waits for the output register to free.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [tmtw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmtw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tmtw_pkg::CMD_W-1:0]      cmd,
  input  wire logic [tmtw_pkg::CHAR_W-1:0]     char_code,
  input  wire logic [tmtw_pkg::RCOL_W-1:0]     read_col,
  input  wire logic [tmtw_pkg::RROW_W-1:0]     read_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tmtw_pkg::OCOL_W-1:0]          cursor_col,
  output logic [tmtw_pkg::OROW_W-1:0]          cursor_row,
  output logic                                 scrolled,
  output logic [tmtw_pkg::CHAR_W-1:0]          cell_char,
  output logic [tmtw_pkg::ATTR_W-1:0]          cell_attr
);

  tmtw_pkg::ctl_cmd_t   ctl;
  tmtw_pkg::dp_status_t sts;

  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tmtw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .char_code  (char_code),
    .read_col   (read_col),
    .read_row   (read_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

`ifndef SYNTHESIS
  // an accepted beat is executed on the very next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ctl.exec)
    else $error("accepted command not executed next cycle");

  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // no input taken while a sweep owns the memory
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (rst)
    (ctl.copy_step || ctl.fill_step) |-> !in_ready)
    else $error("input ready during memory sweep");

  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> !ctl.exec)
    else $error("execute step repeated");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text-mode terminal writer. A cycle-free model
// of the character grid and cursor predicts each result beat; a monitor
// compares every result with the oldest prediction. Stimulus runs directed
// cases first, then random text lines, read bursts, tab and backspace runs,
// clears and noise under several color settings, with random idling on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import tmtw_pkg::*;

  localparam int GRID_COLS = 80;
  localparam int GRID_ROWS = 25;
  localparam int TAB_WIDTH = 4;
  localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_SETTLE = 16;
  localparam int END_SETTLE = 64;

  typedef struct packed {
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              scroll;
    logic [CHAR_W-1:0] chr;
    logic [ATTR_W-1:0] attr;
  } term_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [RCOL_W-1:0] read_col = '0;
  logic [RROW_W-1:0] read_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OCOL_W-1:0] cursor_col;
  logic [OROW_W-1:0] cursor_row;
  logic scrolled;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  text_mode_terminal_writer #(
    .COLUMNS(GRID_COLS),
    .ROWS(GRID_ROWS),
    .TAB_STOP(TAB_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .char_code(char_code),
    .read_col(read_col),
    .read_row(read_row),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .scrolled(scrolled),
    .cell_char(cell_char),
    .cell_attr(cell_attr)
  );

  // grid model
  logic [CHAR_W-1:0] grid_char [GRID_CELLS];
  logic [ATTR_W-1:0] grid_attr [GRID_CELLS];
  int cur_col;
  int cur_row;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  term_report_t expected_reports[$];
  int unsigned commands_sent = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned rx_hold_len = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL text_mode_terminal_writer");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic fill_grid(input logic [ATTR_W-1:0] at);
    for (int i = 0; i < GRID_CELLS; i++) begin
      grid_char[i] = CH_BLANK;
      grid_attr[i] = at;
    end
    cur_col = 0;
    cur_row = 0;
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                                 input logic [RCOL_W-1:0] rc, input logic [RROW_W-1:0] rr,
                                 output term_report_t res);
    logic [ATTR_W-1:0] at;
    res = '0;
    at = {bg_color, fg_color};
    case (c)
      CMD_PUT: begin
        if (ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == CH_RETURN) begin
          cur_col = 0;
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            grid_char[cur_row * GRID_COLS + cur_col] = CH_BLANK;
            grid_attr[cur_row * GRID_COLS + cur_col] = at;
          end
        end else begin
          grid_char[cur_row * GRID_COLS + cur_col] = ch;
          grid_attr[cur_row * GRID_COLS + cur_col] = at;
          cur_col++;
        end
        if (cur_col >= GRID_COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= GRID_ROWS) begin
          // shift everything up one row, blank the bottom row
          for (int i = 0; i < GRID_CELLS - GRID_COLS; i++) begin
            grid_char[i] = grid_char[i + GRID_COLS];
            grid_attr[i] = grid_attr[i + GRID_COLS];
          end
          for (int i = GRID_CELLS - GRID_COLS; i < GRID_CELLS; i++) begin
            grid_char[i] = CH_BLANK;
            grid_attr[i] = at;
          end
          cur_row = GRID_ROWS - 1;
          res.scroll = 1'b1;
        end
      end
      CMD_CLEAR: fill_grid(at);
      CMD_READ: begin
        if (rc < GRID_COLS && rr < GRID_ROWS) begin
          res.chr = grid_char[rr * GRID_COLS + rc];
          res.attr = grid_attr[rr * GRID_COLS + rc];
        end
      end
      default: ;
    endcase
    res.col = cur_col[OCOL_W-1:0];
    res.row = cur_row[OROW_W-1:0];
  endtask

  task automatic send_command(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                              input logic [RCOL_W-1:0] rc, input logic [RROW_W-1:0] rr);
    term_report_t res;
    int unsigned g;
    in_valid <= 1'b1;
    cmd <= c;
    char_code <= ch;
    read_col <= rc;
    read_row <= rr;
    do @(posedge clk); while (!in_ready);
    predict_command(c, ch, rc, rr, res);
    expected_reports.push_back(res);
    commands_sent++;
    g = tx_steady ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_command(CMD_PUT, ch, RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
  endtask

  task automatic read_cell(input int c, input int r);
    send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)), RCOL_W'(c), RROW_W'(r));
  endtask

  // stop offering and wait until every result beat is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic set_colors(input logic [COLOR_W-1:0] f, input logic [COLOR_W-1:0] b);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_data <= f;
    @(posedge clk);
    fg_color = f;
    cfg_index <= REG_BACKGROUND;
    cfg_data <= b;
    @(posedge clk);
    bg_color = b;
    cfg_write <= 1'b0;
  endtask

  task automatic test_reset_grid();
    read_cell(0, 0);
    read_cell(GRID_COLS - 1, GRID_ROWS - 1);
    read_cell(GRID_COLS, 0);
    read_cell(0, GRID_ROWS);
    read_cell(127, 31);
    send_command(CMD_SPARE, 8'hFF, 7'd127, 5'd31);
  endtask

  task automatic test_put_cases();
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_BLANK);
    put_char(CH_BACKSPACE);
    put_char(CH_RETURN);
    put_char(CH_BACKSPACE);   // at column 0: no effect
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_NEWLINE);
    for (int i = 0; i < 4; i++) read_cell(i, 0);
  endtask

  task automatic test_clear();
    set_colors(4'h5, 4'hA);
    send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), RCOL_W'($urandom_range(0, 127)),
                 RROW_W'($urandom_range(0, 31)));
    read_cell(0, 0);
    read_cell(GRID_COLS - 1, GRID_ROWS - 1);
    put_char(8'h7E);
    read_cell(0, 0);
  endtask

  task automatic test_scroll();
    set_colors(4'h3, 4'hC);
    for (int i = 0; i < GRID_ROWS; i++) put_char(CH_NEWLINE);   // last one scrolls
    put_char(8'h5A);
    for (int i = 0; i < GRID_COLS / TAB_WIDTH; i++) put_char(CH_TAB);   // wrap scrolls
    read_cell(0, GRID_ROWS - 2);
    read_cell(0, GRID_ROWS - 1);
  endtask

  task automatic random_session(input int unsigned n);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    int unsigned r2;
    int rrow;
    start = commands_sent;
    while (commands_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // one line of text
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 30) : $urandom_range(31, 100);
        for (int i = 0; i < len; i++) begin
          r2 = $urandom_range(0, 99);
          if (r2 < 85) put_char(CHAR_W'($urandom_range(0, 255)));
          else if (r2 < 91) put_char(CH_TAB);
          else if (r2 < 97) put_char(CH_BACKSPACE);
          else put_char(CH_RETURN);
        end
        r2 = $urandom_range(0, 9);
        if (r2 < 8) put_char(CH_NEWLINE);
        else if (r2 < 9) put_char(CH_RETURN);
      end else if (r < 80) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          r2 = $urandom_range(0, 99);
          if (r2 < 60) begin
            rrow = (cur_row > 0 && $urandom_range(0, 1)) ? cur_row - 1 : cur_row;
            read_cell($urandom_range(0, GRID_COLS - 1), rrow);
          end else if (r2 < 85) begin
            read_cell($urandom_range(0, GRID_COLS - 1), $urandom_range(0, GRID_ROWS - 1));
          end else begin
            read_cell($urandom_range(0, 127), $urandom_range(0, 31));
          end
        end
      end else if (r < 88) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) put_char(CH_BACKSPACE);
      end else if (r < 92) begin
        len = $urandom_range(1, 25);
        for (int i = 0; i < len; i++) put_char(CH_TAB);
      end else if (r < 94) begin
        send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                     RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_command(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                       RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
      end
    end
  endtask

  task automatic test_color_phases();
    set_colors(4'h0, 4'h0);
    random_session(180);
    set_colors(4'hF, 4'hF);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_session(180);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    set_colors(4'h0, 4'hF);
    random_session(180);
    set_colors(4'hF, 4'h0);
    random_session(180);
    for (int p = 0; p < 2; p++) begin
      set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
      random_session(180);
    end
  endtask

  // long output hold-off while the input keeps offering beats
  task automatic test_backpressure();
    wait_idle();
    rx_hold_len = 400;
    tx_steady = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 4) read_cell($urandom_range(0, GRID_COLS - 1), cur_row);
      else put_char(CHAR_W'($urandom_range(0, 255)));
    end
    tx_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_drain();
    random_session(40);
    wait_idle();
    random_session(40);
  endtask

  // output ready driver
  initial begin : out_ready_driver
    int unsigned n;
    forever begin
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    term_report_t got;
    term_report_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{cursor_col, cursor_row, scrolled, cell_char, cell_attr};
      if (expected_reports.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: col %0d row %0d scroll %0d char %02h attr %02h",
                   got.col, got.row, got.scroll, got.chr, got.attr);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected col %0d row %0d scroll %0d char %02h attr %02h,",
                     want.col, want.row, want.scroll, want.chr, want.attr,
                     " got col %0d row %0d scroll %0d char %02h attr %02h",
                     got.col, got.row, got.scroll, got.chr, got.attr);
        end
      end
    end
  end

  initial begin
    fg_color = 4'hF;
    bg_color = 4'h0;
    fill_grid(RESET_ATTR);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_grid();
    test_put_cases();
    test_clear();
    test_scroll();
    test_backpressure();
    test_drain();
    test_color_phases();
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (expected_reports.size() != 0) begin
      fail_count++;
      $display("%0d expected result beats never arrived", expected_reports.size());
    end
    if (fail_count == 0) begin
      $display("PASS text_mode_terminal_writer");
    end else begin
      $display("FAIL text_mode_terminal_writer");
    end
    $finish;
  end

endmodule
